// ===== sv/rfc_pkg.sv =====
// rfc_pkg: constants, codes and types shared by the rectangle fill canvas.
// No dependencies.
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);

  localparam int MAX_RC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int CMP_W  = ($clog2(MAX_RC + 1) > 8) ? $clog2(MAX_RC + 1) : 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef logic [CMP_W-1:0]  coord_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

// ===== sv/rectangle_fill_canvas.sv =====
// rectangle_fill_canvas: character canvas held in one RAM, fill/clear/read items.
// Depends on rfc_pkg and rfc_ram.
`timescale 1ns / 1ps

// A fill item paints its clipped rectangle one cell per cycle, keeping the
// block busy until its last cell (not at all for an empty rectangle); a clear
// item and the clearing pass after reset sweep all 16384 RAM entries, one per
// cycle, and take no item meanwhile. A read item inside the canvas in use
// passes through RAM address, registered RAM data and output load; a read
// outside it skips the RAM read and goes straight to output load. A read also
// waits while an earlier output item is stalled. Configuration writes are taken
// at any time. The RAM write port sets the fill and clear rate.
module rectangle_fill_canvas (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    top_row,
  input  logic [7:0]                    left_col,
  input  logic [7:0]                    bottom_row,
  input  logic [7:0]                    right_col,
  input  logic [7:0]                    paint_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    cell_char
);
  import rfc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_RHOLD = 3'd4;

  logic [2:0]       state;
  logic [7:0]       rows_in_use;
  logic [7:0]       cols_in_use;
  addr_t            clr_addr;
  logic [ROW_W-1:0] row, row_last;
  logic [COL_W-1:0] col, col_first, col_last;
  logic [7:0]       fill_char;
  logic [7:0]       pend_char;

  coord_t rb, cb, top_c, left_c, bot_c, right_c;
  coord_t r0, r1, c0, c1, r0m1, r1m1, c0m1, c1m1, tm1, lm1;
  logic   fill_empty, rd_hit, accept, out_load;

  logic       ram_we, ram_re;
  addr_t      ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_RHOLD) && (!out_valid || out_ready);

  always_comb begin
    top_c   = coord_t'(top_row);
    left_c  = coord_t'(left_col);
    bot_c   = coord_t'(bottom_row);
    right_c = coord_t'(right_col);
    rb = (coord_t'(rows_in_use) < coord_t'(MAX_ROWS)) ? coord_t'(rows_in_use)
                                                      : coord_t'(MAX_ROWS);
    cb = (coord_t'(cols_in_use) < coord_t'(MAX_COLS)) ? coord_t'(cols_in_use)
                                                      : coord_t'(MAX_COLS);
    r0 = (top_c == '0) ? coord_t'(1) : top_c;
    c0 = (left_c == '0) ? coord_t'(1) : left_c;
    r1 = (bot_c < rb) ? bot_c : rb;
    c1 = (right_c < cb) ? right_c : cb;
    fill_empty = (r0 > r1) || (c0 > c1);
    r0m1 = r0 - coord_t'(1);
    r1m1 = r1 - coord_t'(1);
    c0m1 = c0 - coord_t'(1);
    c1m1 = c1 - coord_t'(1);
    tm1  = top_c - coord_t'(1);
    lm1  = left_c - coord_t'(1);
    rd_hit = (top_c != '0) && (top_c <= rb) && (left_c != '0) && (left_c <= cb);
  end

  // reads happen only in idle, writes only in fill/clear: no overlap to forward
  assign ram_we    = (state == ST_FILL) || (state == ST_CLEAR);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : {row, col};
  assign ram_wdata = (state == ST_CLEAR) ? 8'd0 : fill_char;
  assign ram_re    = accept && (cmd == CMD_READ) && rd_hit;
  assign ram_raddr = {tm1[ROW_W-1:0], lm1[COL_W-1:0]};

  rfc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      rows_in_use <= 8'd128;
      cols_in_use <= 8'd128;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default:  ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_FILL: begin
                if (!fill_empty) begin
                  row_last  <= r1m1[ROW_W-1:0];
                  col_first <= c0m1[COL_W-1:0];
                  col_last  <= c1m1[COL_W-1:0];
                  row       <= r0m1[ROW_W-1:0];
                  col       <= c0m1[COL_W-1:0];
                  fill_char <= paint_char;
                  state     <= ST_FILL;
                end
              end
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              CMD_READ: begin
                if (rd_hit) begin
                  state <= ST_RDATA;
                end else begin
                  pend_char <= DOT_CHAR;
                  state     <= ST_RHOLD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_addr == addr_t'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + addr_t'(1);
          end
        end
        ST_FILL: begin
          if (col == col_last) begin
            col <= col_first;
            if (row == row_last) begin
              state <= ST_IDLE;
            end else begin
              row <= row + ROW_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        ST_RDATA: begin
          pend_char <= (ram_rdata == 8'd0) ? DOT_CHAR : ram_rdata;
          state     <= ST_RHOLD;
        end
        ST_RHOLD: begin
          if (out_load) begin
            cell_char <= pend_char;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rfc_ram.sv =====
// rfc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rfc_checker.sv =====
// rfc_checker: port-level assertions for rectangle_fill_canvas, bound to it.
// Depends on rfc_pkg and rectangle_fill_canvas.
`timescale 1ns / 1ps

module rfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] cell_char
);
  import rfc_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_char))
    else $error("output item changed while stalled");

  // unpainted cells always read as dot
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_char != 8'd0)
    else $error("zero character delivered");

  // clearing pass after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken during clearing pass");

  // read and clear items leave the block busy in the cycle after they are taken
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_READ || cmd == CMD_CLEAR) |=> !in_ready)
    else $error("ready right after read or clear item");

endmodule

bind rectangle_fill_canvas rfc_checker u_rfc_checker (.*);
